>>> rtl/core/sql_text_keyword_hint_scanner_assert.svh
// Assertion macros shared by the scanner modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SQL_TEXT_KEYWORD_HINT_SCANNER_ASSERT_SVH
`define SQL_TEXT_KEYWORD_HINT_SCANNER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define SQKH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define SQKH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define SQKH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sqkh_pkg.sv
`default_nettype none

package sqkh_pkg;

  // Widths of the fixed fields.
  localparam int COUNT_BITS_DEF = 16;
  localparam int Q_DEPTH_DEF    = 2;
  localparam int BYTE_W         = 8;
  localparam int HASH_W         = 64;
  localparam int OUT_CNT_W      = 16;
  localparam int BASE_W         = 10;
  localparam int SPAN_W         = 11;
  localparam int THR_W          = 16;
  localparam int TMO_W          = 11;
  localparam int DEPTH_SHIFT    = 48;
  localparam int DEPTH_KEEP     = HASH_W - DEPTH_SHIFT;

  // FNV-1a constants. The prime is 2^40 + 0x1b3.
  localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hcbf29ce484222325;
  localparam int                FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]        FNV_PRIME_LO    = 9'h1b3;

  // Complexity weights.
  localparam int          JOIN_WEIGHT_W = 8;
  localparam int          PRED_WEIGHT_W = 6;
  localparam logic [7:0]  JOIN_WEIGHT   = 8'd131;
  localparam logic [5:0]  PRED_WEIGHT   = 6'd53;

  // Square root and modulo iteration sizes.
  localparam int ROOT_W     = HASH_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SQ_REM_W   = ROOT_W + 2;

  // Configuration port.
  localparam int                 CFG_IDX_W        = 8;
  localparam int                 CFG_DATA_W       = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SPAN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_THR     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_THR     = 8'd3;

  localparam logic [BASE_W-1:0] BASE_RST = 10'd50;
  localparam logic [SPAN_W-1:0] SPAN_RST = 11'd350;
  localparam logic [THR_W-1:0]  JTHR_RST = 16'd2;
  localparam logic [THR_W-1:0]  PTHR_RST = 16'd3;

  // Characters of interest.
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_DIFF  = 8'h20;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_J = 8'h4a;
  localparam logic [7:0] CH_N = 8'h4e;
  localparam logic [7:0] CH_O = 8'h4f;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_W = 8'h57;

  // Keyword matcher states: one per matched prefix, plus a dead state for no match.
  typedef enum logic [3:0] {
    TK_IDLE, TK_J, TK_JO, TK_JOI, TK_JOIN, TK_W, TK_WH, TK_WHE, TK_WHER,
    TK_WHERE, TK_A, TK_AN, TK_AND, TK_O, TK_OR, TK_DEAD
  } tok_state_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_SUM, BK_ROOT, BK_MOD, BK_FIN
  } back_state_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [SPAN_W-1:0] span;
    logic [THR_W-1:0]  join_thr;
    logic [THR_W-1:0]  pred_thr;
  } cfg_regs_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
      r = b - CASE_DIFF;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
  endfunction

  // One FNV-1a round on a sign-extended byte.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] ch);
    logic [HASH_W-1:0] mixed;
    mixed = h ^ {{(HASH_W-8){ch[7]}}, ch};
    return (mixed << FNV_PRIME_SHIFT) + (mixed * HASH_W'(FNV_PRIME_LO));
  endfunction

  // Advance the keyword matcher by one upper-case letter.
  function automatic tok_state_t tok_advance(input tok_state_t st,
                                             input logic [7:0] ch);
    tok_state_t r;
    r = TK_DEAD;
    unique case (st)
      TK_IDLE: begin
        if (ch == CH_J) r = TK_J;
        else if (ch == CH_W) r = TK_W;
        else if (ch == CH_UPPER_A) r = TK_A;
        else if (ch == CH_O) r = TK_O;
      end
      TK_J:    if (ch == CH_O) r = TK_JO;
      TK_JO:   if (ch == CH_I) r = TK_JOI;
      TK_JOI:  if (ch == CH_N) r = TK_JOIN;
      TK_W:    if (ch == CH_H) r = TK_WH;
      TK_WH:   if (ch == CH_E) r = TK_WHE;
      TK_WHE:  if (ch == CH_R) r = TK_WHER;
      TK_WHER: if (ch == CH_E) r = TK_WHERE;
      TK_A:    if (ch == CH_N) r = TK_AN;
      TK_AN:   if (ch == CH_D) r = TK_AND;
      TK_O:    if (ch == CH_R) r = TK_OR;
      default: r = TK_DEAD;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sqkh_if.sv
`default_nettype none

// Text byte channel.
interface sqkh_in_if import sqkh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

// Result channel.
interface sqkh_out_if import sqkh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_CNT_W-1:0] join_total;
  logic [OUT_CNT_W-1:0] predicate_total;
  logic [HASH_W-1:0]    text_weight;
  logic [TMO_W-1:0]     timeout_ms;
  logic                 temp_in_memory;
  logic                 spill_off;

  modport source (output valid, output join_total, output predicate_total,
                  output text_weight, output timeout_ms, output temp_in_memory,
                  output spill_off, input ready);
  modport sink (input valid, input join_total, input predicate_total,
                input text_weight, input timeout_ms, input temp_in_memory,
                input spill_off, output ready);
endinterface

// Configuration write channel.
interface sqkh_cfg_if import sqkh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sqkh_front.sv
`default_nettype none

module sqkh_front import sqkh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sqkh_in_if.sink                           in_ch,
  input  fifo_stat_t                        q_stat,
  output logic                              push,
  output logic [HASH_W+2*COUNT_BITS-1:0]    push_rec
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [HASH_W-1:0]     hash_r, hash_nxt, hash_step;
  logic [COUNT_BITS-1:0] depth_r, depth_nxt, depth_step;
  logic [COUNT_BITS-1:0] join_r, join_nxt, join_step;
  logic [COUNT_BITS-1:0] pred_r, pred_nxt, pred_step;
  tok_state_t            tok_r, tok_nxt, tok_step, tok_close;
  logic [7:0]            ch_up;
  logic                  letter;
  logic                  accept;
  logic [HASH_W-1:0]     weight;

  // Bytes stall only when the queue has no room for a finished text.
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ch_up     = to_upper(in_ch.text_byte);
  assign letter    = is_letter(ch_up);
  assign hash_step = fnv_step(hash_r, ch_up);

  // Parenthesis depth, saturating high and floored at zero.
  always_comb begin
    depth_step = depth_r;
    if (ch_up == CH_LPAREN && depth_r != CNT_MAX) begin
      depth_step = depth_r + COUNT_BITS'(1);
    end else if (ch_up == CH_RPAREN && depth_r != '0) begin
      depth_step = depth_r - COUNT_BITS'(1);
    end
  end

  // Keyword matcher; a non-letter or the end of text closes the token.
  always_comb begin
    tok_step  = letter ? tok_advance(tok_r, ch_up) : TK_IDLE;
    tok_close = letter ? (in_ch.last_byte ? tok_step : TK_IDLE) : tok_r;
    join_step = join_r;
    pred_step = pred_r;
    if (tok_close == TK_JOIN && join_r != CNT_MAX) begin
      join_step = join_r + COUNT_BITS'(1);
    end
    if ((tok_close == TK_WHERE || tok_close == TK_AND || tok_close == TK_OR) &&
        pred_r != CNT_MAX) begin
      pred_step = pred_r + COUNT_BITS'(1);
    end
  end

  assign weight   = hash_step ^ {DEPTH_KEEP'(depth_step), {DEPTH_SHIFT{1'b0}}};
  assign push     = accept && in_ch.last_byte;
  assign push_rec = {weight, join_step, pred_step};

  // The last byte hands the text to the queue and restarts the scan.
  always_comb begin
    hash_nxt  = hash_r;
    depth_nxt = depth_r;
    join_nxt  = join_r;
    pred_nxt  = pred_r;
    tok_nxt   = tok_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        hash_nxt  = FNV_BASIS;
        depth_nxt = '0;
        join_nxt  = '0;
        pred_nxt  = '0;
        tok_nxt   = TK_IDLE;
      end else begin
        hash_nxt  = hash_step;
        depth_nxt = depth_step;
        join_nxt  = join_step;
        pred_nxt  = pred_step;
        tok_nxt   = tok_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= FNV_BASIS;
      depth_r <= '0;
      join_r  <= '0;
      pred_r  <= '0;
      tok_r   <= TK_IDLE;
    end else begin
      hash_r  <= hash_nxt;
      depth_r <= depth_nxt;
      join_r  <= join_nxt;
      pred_r  <= pred_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sqkh_fifo.sv
`default_nettype none
`include "sql_text_keyword_hint_scanner_assert.svh"

module sqkh_fifo import sqkh_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_stat_t       stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SQKH_ASSERT_IMPLIES(a_no_overflow, push, !stat.full, "queue written while full")
  `SQKH_ASSERT_IMPLIES(a_no_underflow, pop, !stat.empty, "queue read while empty")
  `SQKH_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

>>> rtl/core/sqkh_back.sv
`default_nettype none
`include "sql_text_keyword_hint_scanner_assert.svh"

module sqkh_back import sqkh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_regs_t                      cfg,
  input  fifo_stat_t                     q_stat,
  input  logic [HASH_W+2*COUNT_BITS-1:0] pop_rec,
  output logic                           pop,
  sqkh_out_if.source                     out_ch
);

  localparam int PJ_W   = COUNT_BITS + JOIN_WEIGHT_W;
  localparam int PP_W   = COUNT_BITS + PRED_WEIGHT_W;
  localparam int STEP_W = $clog2(SQRT_STEPS);
  localparam int CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  back_state_t           state_r, state_nxt;
  logic [HASH_W-1:0]     weight_r;
  logic [COUNT_BITS-1:0] join_r, pred_r;
  logic [PJ_W-1:0]       prod_j_r;
  logic [PP_W-1:0]       prod_p_r;
  logic [HASH_W-1:0]     cx_r;
  logic [SQ_REM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [SPAN_W-1:0]     mrem_r;
  logic [STEP_W-1:0]     step_r;
  logic                  step_last;

  logic                  out_valid_r;
  logic [OUT_CNT_W-1:0]  join_out_r, pred_out_r;
  logic [HASH_W-1:0]     weight_out_r;
  logic [TMO_W-1:0]      tmo_r;
  logic                  temp_r, spill_r;
  logic                  can_load;

  logic [SQ_REM_W+1:0]   sq_shift, sq_trial;
  logic                  sq_ge;
  logic [SQ_REM_W-1:0]   srem_step;
  logic [SPAN_W-1:0]     span_eff;
  logic [SPAN_W:0]       md_shift;
  logic                  md_ge;
  logic [SPAN_W-1:0]     mrem_step;
  logic [TMO_W:0]        tmo_sum;

  assign step_last = (step_r == STEP_W'(SQRT_STEPS - 1));
  assign can_load  = !out_valid_r || out_ch.ready;

  // One root digit per cycle: bring down two bits, try (4*root + 1).
  assign sq_shift  = {srem_r, cx_r[HASH_W-1 -: 2]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = (sq_shift >= sq_trial);
  assign srem_step = SQ_REM_W'(sq_ge ? sq_shift - sq_trial : sq_shift);

  // One quotient bit per cycle of root modulo span; a zero span acts as one.
  assign span_eff  = (cfg.span == '0) ? SPAN_W'(1) : cfg.span;
  assign md_shift  = {mrem_r, root_r[ROOT_W-1]};
  assign md_ge     = (md_shift >= {1'b0, span_eff});
  assign mrem_step = SPAN_W'(md_ge ? md_shift - {1'b0, span_eff} : md_shift);

  assign tmo_sum   = (TMO_W+1)'(cfg.base) + (TMO_W+1)'(mrem_r);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and queue pop.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:  state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_ROOT;
      BK_ROOT: if (step_last) state_nxt = BK_MOD;
      BK_MOD:  if (step_last) state_nxt = BK_FIN;
      BK_FIN:  if (can_load) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath registers driven by the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        {weight_r, join_r, pred_r} <= pop_rec;
      end
      BK_MUL: begin
        prod_j_r <= PJ_W'(join_r) * PJ_W'(JOIN_WEIGHT);
        prod_p_r <= PP_W'(pred_r) * PP_W'(PRED_WEIGHT);
      end
      BK_SUM: begin
        cx_r   <= weight_r + HASH_W'(prod_j_r) + HASH_W'(prod_p_r) + HASH_W'(1);
        srem_r <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      BK_ROOT: begin
        cx_r   <= cx_r << 2;
        srem_r <= srem_step;
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
        step_r <= step_r + STEP_W'(1);
        mrem_r <= '0;
      end
      BK_MOD: begin
        mrem_r <= mrem_step;
        root_r <= root_r << 1;
        step_r <= step_r + STEP_W'(1);
      end
      BK_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Output register; it is refilled as the previous result leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == BK_FIN && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_FIN && can_load) begin
      join_out_r   <= OUT_CNT_W'(join_r);
      pred_out_r   <= OUT_CNT_W'(pred_r);
      weight_out_r <= weight_r;
      tmo_r        <= TMO_W'(tmo_sum);
      temp_r       <= (CMP_W'(join_r) >= CMP_W'(cfg.join_thr));
      spill_r      <= (CMP_W'(pred_r) >= CMP_W'(cfg.pred_thr));
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.join_total      = join_out_r;
  assign out_ch.predicate_total = pred_out_r;
  assign out_ch.text_weight     = weight_out_r;
  assign out_ch.timeout_ms      = tmo_r;
  assign out_ch.temp_in_memory  = temp_r;
  assign out_ch.spill_off       = spill_r;

  `SQKH_ASSERT_IMPLIES(a_mod_bound, state_r == BK_MOD, mrem_r < span_eff,
                       "modulo remainder not below span")
  `SQKH_ASSERT_NEXT(a_fin_loads, state_r == BK_FIN && can_load, out_valid_r,
                    "finished result not presented")
  `SQKH_ASSERT_IMPLIES(a_pop_idle, pop, state_r == BK_IDLE && !q_stat.empty,
                       "queue popped outside idle")

endmodule

`default_nettype wire

>>> rtl/core/sql_text_keyword_hint_scanner.sv
// A finished text passes through the queue, then the back-end states MUL, SUM, ROOT, MOD
// and FIN, and its result is then registered for the output channel. Text bytes are taken
// one per cycle while the queue has room; the back end works on one text at a time.
// A queue of Q_DEPTH finished texts lets scanning continue while the back end is busy.
// Reset (synchronous, active low) restarts the scan, empties the queue and the output,
// and loads the timeout and threshold registers with their default values.
`default_nettype none

module sql_text_keyword_hint_scanner import sqkh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int Q_DEPTH    = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sqkh_in_if.sink     in_ch,
  sqkh_out_if.source  out_ch,
  sqkh_cfg_if.sink    cfg_ch
);

  localparam int REC_W = HASH_W + 2 * COUNT_BITS;

  cfg_regs_t         cfg_r;
  logic              push, pop;
  logic [REC_W-1:0]  push_rec, pop_rec;
  fifo_stat_t        q_stat;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base     <= BASE_RST;
      cfg_r.span     <= SPAN_RST;
      cfg_r.join_thr <= JTHR_RST;
      cfg_r.pred_thr <= PTHR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        CFG_TIMEOUT_BASE: cfg_r.base     <= BASE_W'(cfg_ch.wdata);
        CFG_TIMEOUT_SPAN: cfg_r.span     <= SPAN_W'(cfg_ch.wdata);
        CFG_JOIN_THR:     cfg_r.join_thr <= THR_W'(cfg_ch.wdata);
        CFG_PRED_THR:     cfg_r.pred_thr <= THR_W'(cfg_ch.wdata);
        default: begin
        end
      endcase
    end
  end

  // Byte scanner.
  sqkh_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  // Queue of finished texts.
  sqkh_fifo #(
    .WIDTH (REC_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .pop_data  (pop_rec),
    .stat      (q_stat)
  );

  // Timeout computation and result register.
  sqkh_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .pop_rec (pop_rec),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> test/tb.sv
module tb;
  import sqkh_pkg::*;

  localparam logic [HASH_W-1:0]    FNV_PRIME_FULL = 64'h0000_0100_0000_01b3;
  localparam logic [OUT_CNT_W-1:0] COUNT_MAX      = 16'hffff;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hff;
  localparam logic [7:0]           CH_SPACE       = 8'h20;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_REPEATS  = 12;
  localparam int DIRECTED_ROWS = 23;

  // One finished text as the block reports it.
  typedef struct packed {
    logic [OUT_CNT_W-1:0] joins;
    logic [OUT_CNT_W-1:0] preds;
    logic [HASH_W-1:0]    weight;
    logic [TMO_W-1:0]     timeout;
    logic                 temp;
    logic                 spill;
  } hint_result_t;

  // One directed byte, with the counts and flags typed in where a text ends.
  typedef struct packed {
    logic [7:0]           ch;
    logic                 lst;
    logic                 typed;
    logic [OUT_CNT_W-1:0] joins;
    logic [OUT_CNT_W-1:0] preds;
    logic                 temp;
    logic                 spill;
  } scan_row_t;

  // Directed texts under the reset configuration: the byte 0x01, a high byte,
  // mixed-case keywords with one ending on the last byte, a close parenthesis
  // at depth zero, and a keyword with a trailing letter.
  scan_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h01, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"j",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"O",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"i",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"N",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"(",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"o",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"R",   1'b1, 1'b1, 16'd1, 16'd1, 1'b0, 1'b0},
    '{"w",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"H",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"e",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"R",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"E",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{")",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"A",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"n",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"D",   1'b1, 1'b1, 16'd0, 16'd2, 1'b0, 1'b0},
    '{"J",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"O",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"I",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"N",   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
    '{"T",   1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}
  };

  string keywords [4] = '{"JOIN", "WHERE", "AND", "OR"};
  string long_pattern = "JOIN(OR(";

  logic clk = 1'b0;
  logic rst_n;

  sqkh_in_if  in_bus ();
  sqkh_out_if res_bus ();
  sqkh_cfg_if cfg_bus ();

  sql_text_keyword_hint_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  // Scanner state and register copy kept by the testbench.
  logic [HASH_W-1:0]    scan_hash;
  logic [OUT_CNT_W-1:0] nest_depth;
  logic [OUT_CNT_W-1:0] join_seen;
  logic [OUT_CNT_W-1:0] pred_count;
  tok_state_t           match_state;
  logic [BASE_W-1:0]    cfg_base;
  logic [SPAN_W-1:0]    cfg_span;
  logic [THR_W-1:0]     cfg_join_thr;
  logic [THR_W-1:0]     cfg_pred_thr;

  hint_result_t pending_hints [$];
  int failures = 0;
  bit idle_on;
  bit hold_off_req;
  int hold_left = 0;
  int stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Next keyword prefix after one more upper-case letter.
  function automatic tok_state_t next_match(input tok_state_t st, input logic [7:0] ch);
    tok_state_t nxt;
    nxt = TK_DEAD;
    case (st)
      TK_IDLE: begin
        if (ch == CH_J) nxt = TK_J;
        else if (ch == CH_W) nxt = TK_W;
        else if (ch == CH_UPPER_A) nxt = TK_A;
        else if (ch == CH_O) nxt = TK_O;
      end
      TK_J:    if (ch == CH_O) nxt = TK_JO;
      TK_JO:   if (ch == CH_I) nxt = TK_JOI;
      TK_JOI:  if (ch == CH_N) nxt = TK_JOIN;
      TK_W:    if (ch == CH_H) nxt = TK_WH;
      TK_WH:   if (ch == CH_E) nxt = TK_WHE;
      TK_WHE:  if (ch == CH_R) nxt = TK_WHER;
      TK_WHER: if (ch == CH_E) nxt = TK_WHERE;
      TK_A:    if (ch == CH_N) nxt = TK_AN;
      TK_AN:   if (ch == CH_D) nxt = TK_AND;
      TK_O:    if (ch == CH_R) nxt = TK_OR;
      default: nxt = TK_DEAD;
    endcase
    return nxt;
  endfunction

  // Exact floor square root, built one result bit at a time from the top.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] ch);
    if ($urandom_range(0, 1) == 1) return ch + CASE_DIFF;
    return ch;
  endfunction

  // Sender gap: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_scan();
    scan_hash   = FNV_BASIS;
    nest_depth  = '0;
    join_seen   = '0;
    pred_count  = '0;
    match_state = TK_IDLE;
  endtask

  // A non-letter or the end of the text closes the current token.
  task automatic close_word();
    if (match_state == TK_JOIN) begin
      if (join_seen != COUNT_MAX) join_seen++;
    end else if (match_state == TK_WHERE || match_state == TK_AND || match_state == TK_OR) begin
      if (pred_count != COUNT_MAX) pred_count++;
    end
    match_state = TK_IDLE;
  endtask

  // Fold one byte into the scan; on the last byte, work out the result.
  task automatic scan_byte(input logic [7:0] raw, input logic lst, output hint_result_t hint);
    logic [7:0]        ch;
    logic [HASH_W-1:0] weight;
    logic [HASH_W-1:0] load;
    logic [HASH_W-1:0] tmo;
    logic [SPAN_W-1:0] span_eff;
    ch = raw;
    if (raw >= CH_LOWER_A && raw <= CH_LOWER_Z) ch = raw - CASE_DIFF;
    scan_hash = (scan_hash ^ {{(HASH_W-8){ch[7]}}, ch}) * FNV_PRIME_FULL;

    if (ch == CH_LPAREN) begin
      if (nest_depth != COUNT_MAX) nest_depth++;
    end else if (ch == CH_RPAREN && nest_depth != 0) begin
      nest_depth--;
    end

    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) match_state = next_match(match_state, ch);
    else close_word();

    hint = '0;
    if (lst) begin
      close_word();
      weight = scan_hash ^ {nest_depth, 48'h0};
      load = weight + 64'(join_seen) * 64'(JOIN_WEIGHT) +
             64'(pred_count) * 64'(PRED_WEIGHT) + 64'd1;
      span_eff = (cfg_span == 0) ? SPAN_W'(1) : cfg_span;
      tmo = 64'(cfg_base) + (64'(floor_sqrt(load)) % 64'(span_eff));
      hint.joins   = join_seen;
      hint.preds   = pred_count;
      hint.weight  = weight;
      hint.timeout = tmo[TMO_W-1:0];
      hint.temp    = (join_seen >= cfg_join_thr);
      hint.spill   = (pred_count >= cfg_pred_thr);
      clear_scan();
    end
  endtask

  // Offer one byte and wait for the transaction; valid stays up for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input hint_result_t typed_hint);
    int gap;
    hint_result_t hint;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.text_byte <= b;
    in_bus.last_byte <= lst;
    do @(posedge clk); while (!in_bus.ready);
    scan_byte(b, lst, hint);
    if (lst) begin
      if (typed) begin
        hint.joins = typed_hint.joins;
        hint.preds = typed_hint.preds;
        hint.temp  = typed_hint.temp;
        hint.spill = typed_hint.spill;
      end
      pending_hints.push_back(hint);
    end
  endtask

  // Build a text from keywords, words and separators, plus some noise bytes.
  task automatic send_random_text(input int max_len, inout int sent);
    logic [7:0] text_q [$];
    int target;
    int r;
    int pick;
    string kw;
    if (max_len > 16 && $urandom_range(0, 99) >= 85) target = $urandom_range(17, max_len);
    else target = $urandom_range(1, (max_len < 16) ? max_len : 16);
    while (text_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if (r < 40) begin
          kw = keywords[$urandom_range(0, 3)];
          for (int k = 0; k < kw.len(); k++) text_q.push_back(mixed_case(kw[k]));
          // Near misses: one letter too many or too few.
          pick = $urandom_range(0, 19);
          if (pick == 0) text_q.push_back(mixed_case(8'(CH_UPPER_A + $urandom_range(0, 25))));
          else if (pick == 1) void'(text_q.pop_back());
        end else begin
          repeat ($urandom_range(1, 6))
            text_q.push_back(mixed_case(8'(CH_UPPER_A + $urandom_range(0, 25))));
        end
        if ($urandom_range(0, 9) < 8) r = 60;
      end
      if (r >= 60 && r < 75) begin
        pick = $urandom_range(0, 9);
        text_q.push_back((pick < 4) ? CH_LPAREN : (pick < 7) ? CH_RPAREN : CH_SPACE);
      end else if (r >= 75) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
    sent += text_q.size();
  endtask

  task automatic random_phase(input int n_bytes, input int max_len);
    int sent;
    sent = 0;
    while (sent < n_bytes) send_random_text(max_len, sent);
  endtask

  // Drop the input and wait until every result is back and the back end is quiet.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_hints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_TIMEOUT_BASE: cfg_base     = data[BASE_W-1:0];
      CFG_TIMEOUT_SPAN: cfg_span     = data[SPAN_W-1:0];
      CFG_JOIN_THR:     cfg_join_thr = data[THR_W-1:0];
      CFG_PRED_THR:     cfg_pred_thr = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] span,
                            input logic [CFG_DATA_W-1:0] jthr, input logic [CFG_DATA_W-1:0] pthr,
                            input bit poke_unused);
    wait_idle();
    if (poke_unused) cfg_write(CFG_UNUSED_IDX, 16'h5a5a);
    cfg_write(CFG_TIMEOUT_BASE, base);
    cfg_write(CFG_TIMEOUT_SPAN, span);
    cfg_write(CFG_JOIN_THR, jthr);
    cfg_write(CFG_PRED_THR, pthr);
    cfg_bus.valid <= 1'b0;
  endtask

  // Stimulus: directed texts, then random texts under several register settings.
  initial begin : stimulus
    hint_result_t typed_hint;
    in_bus.valid      = 1'b0;
    in_bus.text_byte  = '0;
    in_bus.last_byte  = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = '0;
    cfg_bus.wdata     = '0;
    res_bus.ready     = 1'b0;
    rst_n             = 1'b0;
    cfg_base          = BASE_RST;
    cfg_span          = SPAN_RST;
    cfg_join_thr      = JTHR_RST;
    cfg_pred_thr      = PTHR_RST;
    idle_on           = 1'b1;
    hold_off_req      = 1'b0;
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed_hint = '0;
      typed_hint.joins = directed_rows[i].joins;
      typed_hint.preds = directed_rows[i].preds;
      typed_hint.temp  = directed_rows[i].temp;
      typed_hint.spill = directed_rows[i].spill;
      send_byte(directed_rows[i].ch, directed_rows[i].lst, directed_rows[i].typed, typed_hint);
    end

    // Smallest base and span, zero thresholds: flags always set.
    set_config(16'd0, 16'd1, 16'd0, 16'd0, 1'b0);
    random_phase(300, 40);

    // Largest base and thresholds, a span of 1024, no idling, and a long hold-off on the result side
    // while short texts keep coming so the queue fills.
    set_config(16'd1023, 16'd1024, 16'hffff, 16'hffff, 1'b0);
    idle_on = 1'b0;
    hold_off_req = 1'b1;
    random_phase(120, 6);
    random_phase(300, 40);
    idle_on = 1'b1;

    // Zero span acts as one; upper data bits are dropped; unused index is ignored.
    set_config(16'hffff, 16'd0, 16'd1, 16'd2, 1'b1);
    random_phase(300, 40);

    // Widest span with the largest base makes the timeout wrap.
    set_config(16'd1023, 16'h07ff, 16'd3, 16'd5, 1'b0);
    random_phase(300, 40);

    // Middle settings picked at random.
    set_config(16'($urandom_range(0, 1023)), 16'($urandom_range(1, 1024)),
               16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)), 1'b0);
    random_phase(300, 40);

    // One longer text with deep nesting and many keywords, sent back to back.
    set_config(BASE_RST, SPAN_RST, 16'hffff, 16'hffff, 1'b0);
    idle_on = 1'b0;
    for (int n = 0; n < LONG_REPEATS; n++) begin
      for (int k = 0; k < 8; k++) begin
        send_byte(long_pattern[k], (n == LONG_REPEATS - 1) && (k == 7), 1'b0, '0);
      end
    end
    idle_on = 1'b1;
    random_phase(60, 40);

    wait_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: compare each transaction with the oldest pending text, then pick ready.
  always @(posedge clk) begin : result_check
    hint_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_hints.size() == 0) begin
        $error("result with no text pending");
        failures++;
      end else begin
        want = pending_hints.pop_front();
        if (res_bus.join_total !== want.joins) begin
          $error("join_total: expected %0d, got %0d", want.joins, res_bus.join_total);
          failures++;
        end
        if (res_bus.predicate_total !== want.preds) begin
          $error("predicate_total: expected %0d, got %0d", want.preds, res_bus.predicate_total);
          failures++;
        end
        if (res_bus.text_weight !== want.weight) begin
          $error("text_weight: expected %h, got %h", want.weight, res_bus.text_weight);
          failures++;
        end
        if (res_bus.timeout_ms !== want.timeout) begin
          $error("timeout_ms: expected %0d, got %0d", want.timeout, res_bus.timeout_ms);
          failures++;
        end
        if (res_bus.temp_in_memory !== want.temp) begin
          $error("temp_in_memory: expected %0b, got %0b", want.temp, res_bus.temp_in_memory);
          failures++;
        end
        if (res_bus.spill_off !== want.spill) begin
          $error("spill_off: expected %0b, got %0b", want.spill, res_bus.spill_off);
          failures++;
        end
      end
    end

    if (hold_off_req) begin
      hold_left = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      if (idle_on) begin
        case ($urandom_range(0, 19))
          0, 1, 2:   stall_left = $urandom_range(1, 4);
          3:         stall_left = $urandom_range(15, 80);
          default:   stall_left = 0;
        endcase
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
